/* hw/rtl/bba_pkg.sv */
`timescale 1ns / 1ps

package bba_pkg;

    // Field widths of the block table and the item channels
    localparam int ORDER_W = 5;
    localparam int OWNER_W = 32;
    localparam int SIZE_W  = 31;
    localparam int COUNT_W = 7;

    typedef logic [ORDER_W-1:0] t_order;
    typedef logic [OWNER_W-1:0] t_owner;
    typedef logic [SIZE_W-1:0]  t_size;
    typedef logic [COUNT_W-1:0] t_count;

    // Largest pool order and the pool order after reset
    localparam t_order ORDER_LIMIT    = 5'd30;
    localparam t_order POOL_ORDER_RST = 5'd10;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_ENTRY  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_SPACE   = 2'd1,
        STAT_TABLE_FULL = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd   command;
        t_owner owner_id;
        t_size  request_size;
    } t_in_item;

    typedef struct packed {
        t_kind   result_kind;
        t_status status;
        t_count  block_count;
        t_owner  block_owner;
        logic    last;
    } t_out_item;

    // One entry of the block table
    typedef struct packed {
        t_order order;
        logic   used;
        t_owner owner;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_SPLIT_LO,
        ST_SPLIT_HI,
        ST_REPLY,
        ST_QRD,
        ST_QOUT
    } t_state;

    // Smallest k with 2^k >= size; zero and one give 0, above 2^30 gives 31
    function automatic t_order order_for(input t_size size);
        t_size  m;
        t_order k;
        m = size - t_size'(1);
        k = '0;
        if (size > t_size'(1)) begin
            for (int i = 0; i < SIZE_W; i++) begin
                if (m[i]) begin
                    k = t_order'(i + 1);
                end
            end
        end
        return k;
    endfunction

    // Limit a written pool order to the largest legal order
    function automatic t_order clamp_order(input t_order v);
        return (v > ORDER_LIMIT) ? ORDER_LIMIT : v;
    endfunction

endpackage

/* hw/rtl/bba_ram.sv */
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/buddy_block_allocator_top.sv */
`timescale 1ns / 1ps

// Buddy block allocator. The block list lives in one simple dual-port table
// with a registered read. An allocate scans the list once, then either marks
// the exact fit (one write), replies with a status when there is no larger
// free block or the table is full, or splits the first larger free block:
// the entries after it move back one per cycle and two writes lay down the
// halves, after which the scan repeats. Each split lowers the order by one,
// so an allocate takes at most about 31 scans. A query reads each block in
// turn and puts out one entry per block, waiting while the output stalls.
// The next item is taken once the current one has placed its last result
// in the output register. Entry 0 after reset or a pool order write is
// supplied from a flag, so no clearing pass is needed; a pool order write
// takes effect at once and must only be made while the block is idle.
module buddy_block_allocator_top #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bba_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bba_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  bba_pkg::t_order    i_cfg_wdata
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    bba_pkg::t_state    r_state, n_state;
    bba_pkg::t_order    r_pool_order;
    logic [CW-1:0]      r_total, n_total;
    logic               r_head_fresh, n_head_fresh;
    bba_pkg::t_order    r_k, n_k;
    bba_pkg::t_owner    r_owner, n_owner;
    logic [CW-1:0]      r_rd_idx, n_rd_idx;
    logic               r_chk_vld, n_chk_vld;
    logic               r_ex_found, n_ex_found;
    logic [AW-1:0]      r_ex_idx, n_ex_idx;
    logic               r_lg_found, n_lg_found;
    logic [AW-1:0]      r_lg_idx, n_lg_idx;
    bba_pkg::t_order    r_lg_ord, n_lg_ord;
    logic [AW-1:0]      r_sh_idx, n_sh_idx;
    logic               r_sh_more, n_sh_more;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_pend_dst, n_pend_dst;
    logic [AW-1:0]      r_q_idx, n_q_idx;
    logic               r_rd_was0, n_rd_was0;
    bba_pkg::t_status   r_status, n_status;
    logic               r_out_valid, n_out_valid;
    bba_pkg::t_out_item r_out, n_out;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    bba_pkg::t_entry    ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    bba_pkg::t_entry    ram_rdata;
    bba_pkg::t_entry    rd_entry;

    logic               in_xfer;
    logic               out_free;
    logic               out_load;
    logic               scan_issue;
    logic               table_full;
    logic               shift_needed;
    logic               q_last;
    bba_pkg::t_order    half_order;

    // Block table
    bba_ram #(
        .WIDTH (bba_pkg::ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Substitute the fresh head entry until entry 0 is first written
    always_comb begin
        rd_entry = ram_rdata;
        if (r_rd_was0 && r_head_fresh) begin
            rd_entry = '{order: r_pool_order, used: 1'b0, owner: '0};
        end
    end

    assign in_xfer      = i_in_valid && !o_in_stall;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign scan_issue   = r_rd_idx < r_total;
    assign table_full   = r_total == CW'(MAX_BLOCKS);
    assign shift_needed = (CW'(r_lg_idx) + CW'(2)) <= r_total;
    assign q_last       = (CW'(r_q_idx) + CW'(1)) == r_total;
    assign half_order   = r_lg_ord - bba_pkg::t_order'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bba_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_data.command == bba_pkg::CMD_QUERY) ?
                              bba_pkg::ST_QRD : bba_pkg::ST_SCAN;
                end
            end
            bba_pkg::ST_SCAN: begin
                if (!scan_issue && !r_chk_vld) begin
                    n_state = bba_pkg::ST_DECIDE;
                end
            end
            bba_pkg::ST_DECIDE: begin
                if (r_ex_found || !r_lg_found || table_full) begin
                    n_state = bba_pkg::ST_REPLY;
                end else if (shift_needed) begin
                    n_state = bba_pkg::ST_SHIFT;
                end else begin
                    n_state = bba_pkg::ST_SPLIT_LO;
                end
            end
            bba_pkg::ST_SHIFT: begin
                if (!r_sh_more && !r_pend) begin
                    n_state = bba_pkg::ST_SPLIT_LO;
                end
            end
            bba_pkg::ST_SPLIT_LO: n_state = bba_pkg::ST_SPLIT_HI;
            bba_pkg::ST_SPLIT_HI: n_state = bba_pkg::ST_SCAN;
            bba_pkg::ST_REPLY: begin
                if (out_free) begin
                    n_state = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_QRD: n_state = bba_pkg::ST_QOUT;
            bba_pkg::ST_QOUT: begin
                if (out_free) begin
                    n_state = q_last ? bba_pkg::ST_IDLE : bba_pkg::ST_QRD;
                end
            end
            default: n_state = bba_pkg::ST_IDLE;
        endcase
    end

    // Datapath, table access and output register loading per state
    always_comb begin
        n_total      = r_total;
        n_head_fresh = r_head_fresh;
        n_k          = r_k;
        n_owner      = r_owner;
        n_rd_idx     = r_rd_idx;
        n_chk_vld    = 1'b0;
        n_ex_found   = r_ex_found;
        n_ex_idx     = r_ex_idx;
        n_lg_found   = r_lg_found;
        n_lg_idx     = r_lg_idx;
        n_lg_ord     = r_lg_ord;
        n_sh_idx     = r_sh_idx;
        n_sh_more    = r_sh_more;
        n_pend       = 1'b0;
        n_pend_dst   = r_pend_dst;
        n_q_idx      = r_q_idx;
        n_status     = r_status;
        n_out        = r_out;
        out_load     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        unique case (r_state)
            bba_pkg::ST_IDLE: begin
                // capture the command and arm the first scan
                if (in_xfer) begin
                    n_k        = bba_pkg::order_for(i_in_data.request_size);
                    n_owner    = i_in_data.owner_id;
                    n_q_idx    = '0;
                    n_rd_idx   = '0;
                    n_ex_found = 1'b0;
                    n_lg_found = 1'b0;
                end
            end
            bba_pkg::ST_SCAN: begin
                // read the next entry, check the one that came back
                ram_re    = scan_issue;
                ram_raddr = r_rd_idx[AW-1:0];
                n_chk_vld = scan_issue;
                if (scan_issue) begin
                    n_rd_idx = r_rd_idx + CW'(1);
                end
                if (r_chk_vld && !rd_entry.used) begin
                    if (rd_entry.order == r_k && !r_ex_found) begin
                        n_ex_found = 1'b1;
                        n_ex_idx   = r_rd_idx[AW-1:0] - AW'(1);
                    end
                    if (rd_entry.order > r_k && !r_lg_found) begin
                        n_lg_found = 1'b1;
                        n_lg_idx   = r_rd_idx[AW-1:0] - AW'(1);
                        n_lg_ord   = rd_entry.order;
                    end
                end
            end
            bba_pkg::ST_DECIDE: begin
                if (r_ex_found) begin
                    // take the exact fit
                    ram_we    = 1'b1;
                    ram_waddr = r_ex_idx;
                    ram_wdata = '{order: r_k, used: 1'b1, owner: r_owner};
                    n_status  = bba_pkg::STAT_OK;
                    if (r_ex_idx == '0) begin
                        n_head_fresh = 1'b0;
                    end
                end else if (!r_lg_found) begin
                    n_status = bba_pkg::STAT_NO_SPACE;
                end else if (table_full) begin
                    n_status = bba_pkg::STAT_TABLE_FULL;
                end else begin
                    // start moving entries back from the tail
                    n_sh_idx  = r_total[AW-1:0] - AW'(1);
                    n_sh_more = shift_needed;
                end
            end
            bba_pkg::ST_SHIFT: begin
                // read source j-1, write it to j in the next cycle
                if (r_sh_more) begin
                    ram_re     = 1'b1;
                    ram_raddr  = r_sh_idx;
                    n_pend     = 1'b1;
                    n_pend_dst = r_sh_idx + AW'(1);
                    if (r_sh_idx == r_lg_idx + AW'(1)) begin
                        n_sh_more = 1'b0;
                    end else begin
                        n_sh_idx = r_sh_idx - AW'(1);
                    end
                end
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pend_dst;
                    ram_wdata = ram_rdata;
                end
            end
            bba_pkg::ST_SPLIT_LO: begin
                ram_we    = 1'b1;
                ram_waddr = r_lg_idx;
                ram_wdata = '{order: half_order, used: 1'b0, owner: '0};
                if (r_lg_idx == '0) begin
                    n_head_fresh = 1'b0;
                end
            end
            bba_pkg::ST_SPLIT_HI: begin
                // lay down the upper half and rescan
                ram_we     = 1'b1;
                ram_waddr  = r_lg_idx + AW'(1);
                ram_wdata  = '{order: half_order, used: 1'b0, owner: '0};
                n_total    = r_total + CW'(1);
                n_rd_idx   = '0;
                n_ex_found = 1'b0;
                n_lg_found = 1'b0;
            end
            bba_pkg::ST_REPLY: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_out    = '{result_kind: bba_pkg::KIND_STATUS,
                                 status:      r_status,
                                 block_count: bba_pkg::t_count'(r_total),
                                 block_owner: '0,
                                 last:        1'b1};
                end
            end
            bba_pkg::ST_QRD: begin
                ram_re    = 1'b1;
                ram_raddr = r_q_idx;
            end
            bba_pkg::ST_QOUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_out    = '{result_kind: bba_pkg::KIND_ENTRY,
                                 status:      bba_pkg::STAT_OK,
                                 block_count: bba_pkg::t_count'(r_total),
                                 block_owner: rd_entry.owner,
                                 last:        q_last};
                    if (!q_last) begin
                        n_q_idx = r_q_idx + AW'(1);
                    end
                end
            end
            default: begin
            end
        endcase

        n_rd_was0   = ram_re ? (ram_raddr == '0) : r_rd_was0;
        n_out_valid = out_load || (r_out_valid && i_out_stall);
    end

    // Control registers; a pool order write reloads the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bba_pkg::ST_IDLE;
            r_pool_order <= bba_pkg::POOL_ORDER_RST;
            r_total      <= CW'(1);
            r_head_fresh <= 1'b1;
            r_chk_vld    <= 1'b0;
            r_sh_more    <= 1'b0;
            r_pend       <= 1'b0;
            r_rd_was0    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_total      <= n_total;
            r_head_fresh <= n_head_fresh;
            r_chk_vld    <= n_chk_vld;
            r_sh_more    <= n_sh_more;
            r_pend       <= n_pend;
            r_rd_was0    <= n_rd_was0;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_pool_order <= bba_pkg::clamp_order(i_cfg_wdata);
                r_total      <= CW'(1);
                r_head_fresh <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_owner    <= n_owner;
        r_rd_idx   <= n_rd_idx;
        r_ex_found <= n_ex_found;
        r_ex_idx   <= n_ex_idx;
        r_lg_found <= n_lg_found;
        r_lg_idx   <= n_lg_idx;
        r_lg_ord   <= n_lg_ord;
        r_sh_idx   <= n_sh_idx;
        r_pend_dst <= n_pend_dst;
        r_q_idx    <= n_q_idx;
        r_status   <= n_status;
        r_out      <= n_out;
    end

    assign o_in_stall  = r_state != bba_pkg::ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Block count stays between one and the table depth
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total != '0) && (r_total <= CW'(MAX_BLOCKS)))
        else $error("block count out of range");

    // Never read and write the same entry in one cycle
    a_port_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("table read and write collide");

    // A split only completes when the table has room
    a_split_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::ST_SPLIT_HI) |-> (r_total < CW'(MAX_BLOCKS)))
        else $error("split with full table");

    // Without a pool order write the list never shrinks
    a_total_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !i_cfg_we) |=> (r_total >= $past(r_total)))
        else $error("block count decreased");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import bba_pkg::*;

    localparam int TABLE_DEPTH = 64;

    logic      i_clk       = 1'b0;
    logic      rst_n       = 1'b0;
    logic      in_valid    = 1'b0;
    t_in_item  in_data     = '0;
    logic      out_stall   = 1'b0;
    logic      cfg_we      = 1'b0;
    t_order    cfg_wdata   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    // Local copy of the block list and the pool order
    t_order    cur_pool_order;
    t_order    tbl_order [TABLE_DEPTH];
    logic      tbl_used  [TABLE_DEPTH];
    t_owner    tbl_owner [TABLE_DEPTH];
    int        tbl_count;

    t_out_item pending_results[$];
    t_status   last_alloc_status;
    bit        steady_mode = 1'b0;
    int        stall_left  = 0;
    int        error_count = 0;
    int        n_alloc_ok, n_no_space, n_table_full, n_queries, n_results, n_pool_writes;

    buddy_block_allocator_top #(
        .MAX_BLOCKS(TABLE_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Reload the list with one free block covering the pool
    function automatic void reload_list(t_order po);
        cur_pool_order = po;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_order[i] = '0;
            tbl_used[i]  = 1'b0;
            tbl_owner[i] = '0;
        end
        tbl_order[0] = po;
        tbl_count    = 1;
    endfunction

    // Smallest k with 2^k >= units; zero counts as one unit, 31 when too big
    function automatic t_order units_to_order(t_size units);
        int k;
        k = 0;
        while (k < 31 && (longint'(1) << k) < longint'(units)) begin
            k++;
        end
        return t_order'(k);
    endfunction

    // Take the first exact fit, else halve the first larger free block and retry
    function automatic t_status carve_block(t_owner id, t_size units);
        t_order want;
        int     hit;
        want = units_to_order(units);
        for (int pass = 0; pass < 64; pass++) begin
            hit = -1;
            for (int i = 0; i < tbl_count; i++) begin
                if (!tbl_used[i] && tbl_order[i] == want) begin
                    tbl_used[i]  = 1'b1;
                    tbl_owner[i] = id;
                    return STAT_OK;
                end
            end
            for (int i = 0; i < tbl_count; i++) begin
                if (!tbl_used[i] && tbl_order[i] > want) begin
                    hit = i;
                    break;
                end
            end
            if (hit < 0) begin
                return STAT_NO_SPACE;
            end
            if (tbl_count >= TABLE_DEPTH) begin
                return STAT_TABLE_FULL;
            end
            for (int j = tbl_count; j > hit + 1; j--) begin
                tbl_order[j] = tbl_order[j-1];
                tbl_used[j]  = tbl_used[j-1];
                tbl_owner[j] = tbl_owner[j-1];
            end
            tbl_order[hit]   = tbl_order[hit] - t_order'(1);
            tbl_order[hit+1] = tbl_order[hit];
            tbl_used[hit]    = 1'b0;
            tbl_used[hit+1]  = 1'b0;
            tbl_owner[hit]   = '0;
            tbl_owner[hit+1] = '0;
            tbl_count++;
        end
        return STAT_NO_SPACE;
    endfunction

    // Queue one status for an allocate, or one entry per block for a query
    function automatic void predict_results(t_in_item it);
        t_out_item r;
        r = '0;
        if (it.command == CMD_ALLOC) begin
            last_alloc_status = carve_block(it.owner_id, it.request_size);
            case (last_alloc_status)
                STAT_OK:       n_alloc_ok++;
                STAT_NO_SPACE: n_no_space++;
                default:       n_table_full++;
            endcase
            r.result_kind = KIND_STATUS;
            r.status      = last_alloc_status;
            r.block_count = t_count'(tbl_count);
            r.block_owner = '0;
            r.last        = 1'b1;
            pending_results.push_back(r);
        end else begin
            n_queries++;
            for (int i = 0; i < tbl_count; i++) begin
                r.result_kind = KIND_ENTRY;
                r.status      = STAT_OK;
                r.block_count = t_count'(tbl_count);
                r.block_owner = tbl_owner[i];
                r.last        = (i == tbl_count - 1);
                pending_results.push_back(r);
            end
        end
    endfunction

    // Mostly sizes that fit the pool, with zero, exact powers and raw values mixed in
    function automatic t_size pick_request_size();
        int r;
        int k;
        int top;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end
        if (r < 12) begin
            return t_size'($urandom);
        end
        if (r < 17) begin
            return t_size'(1) << $urandom_range(0, 30);
        end
        top = (cur_pool_order >= 30) ? 30 : int'(cur_pool_order) + 1;
        if ($urandom_range(0, 1) == 1) begin
            k = $urandom_range(0, (top < 3) ? top : 3);
        end else begin
            k = $urandom_range(0, top);
        end
        if (k == 0) begin
            return t_size'(1);
        end
        return (t_size'(1) << (k - 1)) + t_size'($urandom_range(1, 1 << (k - 1)));
    endfunction

    // Present one item, hold it until the transfer, then predict its results
    task automatic send_item(t_cmd cmd, t_owner id, t_size units);
        t_in_item it;
        int       gap;
        it.command      = cmd;
        it.owner_id     = id;
        it.request_size = units;
        if (!steady_mode && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_results(it);
    endtask

    // Stop sending and wait until every queued result has arrived
    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Write the pool order with the block idle
    task automatic write_pool_order(t_order v);
        drain_results();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        reload_list((v > ORDER_LIMIT) ? ORDER_LIMIT : v);
        n_pool_writes++;
    endtask

    // Stall the result channel in random bursts
    always @(negedge i_clk) begin
        if (!rst_n || steady_mode) begin
            stall_left = 0;
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Compare every result transfer with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (rst_n && o_out_valid && !out_stall) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: %h", o_out_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.result_kind !== want.result_kind) begin
                    $error("result_kind: expected %0d, got %0d",
                           want.result_kind, o_out_data.result_kind);
                    error_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    error_count++;
                end
                if (o_out_data.block_count !== want.block_count) begin
                    $error("block_count: expected %0d, got %0d",
                           want.block_count, o_out_data.block_count);
                    error_count++;
                end
                if (o_out_data.block_owner !== want.block_owner) begin
                    $error("block_owner: expected %h, got %h",
                           want.block_owner, o_out_data.block_owner);
                    error_count++;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_out_data.last);
                    error_count++;
                end
            end
        end
    end

    // List right after reset: one free block of the default order
    task automatic test_reset_query();
        send_item(CMD_QUERY, '0, '0);
    endtask

    // Zero request splits down to order 0, then exact fits and a deeper split
    task automatic test_split_and_fit();
        send_item(CMD_ALLOC, 32'hFFFF_FFFF, '0);
        send_item(CMD_ALLOC, '0, t_size'(1));
        send_item(CMD_ALLOC, t_owner'($urandom), t_size'(3));
        send_item(CMD_ALLOC, t_owner'($urandom), t_size'(4));
        send_item(CMD_QUERY, t_owner'($urandom), t_size'($urandom));
    endtask

    // Requests larger than the pool or beyond any legal order
    task automatic test_oversized_request();
        send_item(CMD_ALLOC, t_owner'($urandom), t_size'(1) << 30);
        send_item(CMD_ALLOC, t_owner'($urandom), {SIZE_W{1'b1}});
        send_item(CMD_ALLOC, t_owner'($urandom), (t_size'(1) << 30) + t_size'(1));
    endtask

    // Pool order extremes: clamped write, largest pool, single unit pool
    task automatic test_pool_order_limits();
        write_pool_order(5'd31);
        send_item(CMD_ALLOC, t_owner'($urandom), t_size'(1) << 30);
        send_item(CMD_ALLOC, t_owner'($urandom), t_size'(1));
        send_item(CMD_QUERY, '0, '0);
        write_pool_order(ORDER_LIMIT);
        send_item(CMD_ALLOC, t_owner'($urandom), t_size'(1));
        send_item(CMD_QUERY, '0, '0);
        write_pool_order(5'd0);
        send_item(CMD_ALLOC, t_owner'($urandom), '0);
        send_item(CMD_ALLOC, t_owner'($urandom), t_size'(2));
        send_item(CMD_ALLOC, t_owner'($urandom), t_size'(1));
        send_item(CMD_QUERY, '0, '0);
    endtask

    // Fill a 128 unit pool with single units until a split finds the table full
    task automatic test_table_full();
        write_pool_order(5'd7);
        for (int n = 0; n < 100; n++) begin
            send_item(CMD_ALLOC, t_owner'($urandom), t_size'($urandom_range(0, 1)));
            if (last_alloc_status == STAT_TABLE_FULL) begin
                break;
            end
        end
        send_item(CMD_QUERY, '0, '0);
        send_item(CMD_ALLOC, t_owner'($urandom), t_size'(2));
    endtask

    // Random allocates and queries over a range of pool orders
    task automatic test_random_phases();
        t_order po;
        for (int p = 0; p < 9; p++) begin
            case (p)
                0:       po = 5'd31;
                1:       po = 5'd0;
                2:       po = ORDER_LIMIT;
                default: po = ($urandom_range(0, 3) == 0) ? t_order'($urandom_range(0, 31))
                                                          : t_order'($urandom_range(2, 9));
            endcase
            write_pool_order(po);
            for (int n = 0; n < 35; n++) begin
                if (n == 17 && p[0]) begin
                    drain_results();
                end
                if ($urandom_range(0, 99) < 15) begin
                    send_item(CMD_QUERY, t_owner'($urandom), t_size'($urandom));
                end else begin
                    send_item(CMD_ALLOC, t_owner'($urandom), pick_request_size());
                end
            end
        end
    endtask

    // Back-to-back items with no input gaps and no result stall
    task automatic test_steady_stream();
        write_pool_order(5'd8);
        steady_mode = 1'b1;
        for (int n = 0; n < 40; n++) begin
            if ($urandom_range(0, 99) < 15) begin
                send_item(CMD_QUERY, t_owner'($urandom), t_size'($urandom));
            end else begin
                send_item(CMD_ALLOC, t_owner'($urandom), pick_request_size());
            end
        end
    endtask

    initial begin
        reload_list(POOL_ORDER_RST);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        test_reset_query();
        test_split_and_fit();
        test_oversized_request();
        test_pool_order_limits();
        test_table_full();
        test_random_phases();
        test_steady_stream();

        // Let the last results out and watch for anything extra
        drain_results();
        repeat (300) @(posedge i_clk);

        $display("Covered %0d allocates (%0d ok, %0d no space, %0d table full) and %0d queries",
                 n_alloc_ok + n_no_space + n_table_full, n_alloc_ok, n_no_space,
                 n_table_full, n_queries);
        $display("Checked %0d results across %0d pool order writes", n_results, n_pool_writes);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #16_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
